>>> design/hdrft_pkg.sv
// shared types and constants for the rumble frame transcoder
package hdrft_pkg;

    localparam int FRAME_W     = 40;
    localparam int AMP_IN_W    = 16;
    localparam int AMP_OUT_W   = 10;
    localparam int FREQ_W      = 9;

    localparam logic [7:0] REPORT_LENGTH    = 8'd64;
    localparam logic [7:0] REPORT_TAG       = 8'h02;
    localparam logic [3:0] COMMAND_NIBBLE   = 4'h5;
    localparam logic [FRAME_W-1:0] ZERO_PATTERN = 40'h00_1E10_00E1;

    // amplitude rescale: (amp * 1023 + 32767) / 65535
    localparam logic [AMP_IN_W-1:0] AMP_IN_MAX   = 16'hFFFF;
    localparam logic [AMP_IN_W-1:0] AMP_ROUND    = 16'h7FFF;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_LENGTH = 2'd1,
        STATUS_BAD_REPORT = 2'd2,
        STATUS_NO_LINK    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]         report_length;
        logic [7:0]         report_tag;
        logic [7:0]         command_byte;
        logic [FRAME_W-1:0] left_frame;
        logic [FRAME_W-1:0] right_frame;
        logic               link_connected;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               effect_active;
        logic [FRAME_W-1:0] left_vibration;
        logic [FRAME_W-1:0] right_vibration;
    } out_t;

    // what one frame lane hands to the merge stage
    typedef struct packed {
        logic               active;
        logic [FRAME_W-1:0] word;
    } lane_result_t;

endpackage

>>> design/hd_rumble_frame_transcoder.sv
// top level: report checks, two frame lanes and the merging output stage
// the result of an accepted request is written into the output register
// throughput: one request per cycle; a new request is taken while out_ready is high
// or the output register is empty, set by the single output register
// reset: rst_n clears the output valid flag; no other state
module hd_rumble_frame_transcoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hdrft_pkg::in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output hdrft_pkg::out_t out_data
);
    import hdrft_pkg::*;

    lane_result_t left_result;
    lane_result_t right_result;
    status_t      status;
    out_t         merged;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_t         out_data_reg;

    hdrft_lane u_left_lane (
        .frame  (in_data.left_frame),
        .result (left_result)
    );

    hdrft_lane u_right_lane (
        .frame  (in_data.right_frame),
        .result (right_result)
    );

    // first failing check wins
    always_comb
    begin
        if (in_data.report_length != REPORT_LENGTH)
        begin
            status = STATUS_BAD_LENGTH;
        end
        else if (in_data.report_tag != REPORT_TAG ||
                 in_data.command_byte[7:4] != COMMAND_NIBBLE)
        begin
            status = STATUS_BAD_REPORT;
        end
        else if (!in_data.link_connected)
        begin
            status = STATUS_NO_LINK;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // merge: both words go out only when the status is OK and some amplitude is nonzero
    always_comb
    begin
        merged.status = status;
        if (status == STATUS_OK && (left_result.active || right_result.active))
        begin
            merged.effect_active   = 1'b1;
            merged.left_vibration  = left_result.word;
            merged.right_vibration = right_result.word;
        end
        else
        begin
            merged.effect_active   = 1'b0;
            merged.left_vibration  = ZERO_PATTERN;
            merged.right_vibration = ZERO_PATTERN;
        end
    end

    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            out_data_reg <= merged;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/hdrft_amp_scale.sv
// rescales a 16-bit amplitude to 0..1023 with rounding
module hdrft_amp_scale (
    input  logic [hdrft_pkg::AMP_IN_W-1:0]  amp,
    output logic [hdrft_pkg::AMP_OUT_W-1:0] scaled
);
    import hdrft_pkg::*;

    localparam int PROD_W = AMP_IN_W + AMP_OUT_W;

    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    biased;
    logic [AMP_OUT_W-1:0] quot;
    logic [AMP_IN_W:0]    rem;

    // amp * 1023 as a shift and subtract
    assign prod   = {amp, {AMP_OUT_W{1'b0}}} - {{AMP_OUT_W{1'b0}}, amp};
    assign biased = prod + {{AMP_OUT_W{1'b0}}, AMP_ROUND};

    // divide by 2^16-1: quotient estimate from the top bits, remainder below 2x divisor
    assign quot = biased[PROD_W-1:AMP_IN_W];
    assign rem  = {1'b0, biased[AMP_IN_W-1:0]} + {{(AMP_IN_W+1-AMP_OUT_W){1'b0}}, quot};

    always_comb
    begin
        if (rem >= {1'b0, AMP_IN_MAX})
        begin
            scaled = quot + {{(AMP_OUT_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            scaled = quot;
        end
    end

endmodule

>>> design/hdrft_lane.sv
// one motor frame lane: unpacks, rescales and repacks a 5-byte frame
module hdrft_lane (
    input  logic [hdrft_pkg::FRAME_W-1:0] frame,
    output hdrft_pkg::lane_result_t       result
);
    import hdrft_pkg::*;

    logic [7:0]           b0, b1, b2, b3, b4;
    logic [AMP_IN_W-1:0]  hi_amp;
    logic [AMP_IN_W-1:0]  lo_amp;
    logic [FREQ_W-1:0]    hi_freq;
    logic [FREQ_W-1:0]    lo_freq;
    logic [AMP_OUT_W-1:0] high_scaled;
    logic [AMP_OUT_W-1:0] low_scaled;

    assign b0 = frame[7:0];
    assign b1 = frame[15:8];
    assign b2 = frame[23:16];
    assign b3 = frame[31:24];
    assign b4 = frame[39:32];

    assign hi_amp  = {b2[3:0], b1[7:2], 6'b0};
    assign lo_amp  = {b4, b3[7:6], 6'b0};
    // 10-bit frequencies, top bit dropped
    assign hi_freq = {b1[0], b0};
    assign lo_freq = {b3[4:0], b2[7:4]};

    hdrft_amp_scale u_high_scale (
        .amp    (hi_amp),
        .scaled (high_scaled)
    );

    hdrft_amp_scale u_low_scale (
        .amp    (lo_amp),
        .scaled (low_scaled)
    );

    // tone bits stay clear
    assign result.word   = {high_scaled, 1'b0, hi_freq, low_scaled, 1'b0, lo_freq};
    assign result.active = (|hi_amp) | (|lo_amp);

endmodule
